// ===== rtl/v3nl_pkg.sv =====
// Package for the 3D vector normalize/length pipeline.
// Holds operation codes, pipeline depths and shared payload types; no dependencies.
`default_nettype none

package v3nl_pkg;

  typedef enum logic [1:0] {
    OP_NORM = 2'd0,
    OP_DIFF = 2'd1,
    OP_LEN  = 2'd2,
    OP_RSVD = 2'd3
  } op_e;

  localparam int unsigned LANES      = 3;
  localparam int unsigned SQRT_STEPS = 34;  // root bits 33..0
  localparam int unsigned DIV_STEPS  = 31;  // quotient bits 30..0
  localparam int unsigned DIV_LAT    = DIV_STEPS + 1;

  // Payload that rides along the square-root pipeline.
  typedef struct packed {
    op_e                           op;
    logic [LANES-1:0][32:0]        v;   // signed 33-bit component
    logic [LANES-1:0][32:0]        m;   // magnitude
  } sq_pay_t;

endpackage

`default_nettype wire

// ===== rtl/v3nl_lane.sv =====
// One component lane: optional difference, magnitude and square.
// Depends on nothing outside this file; two register stages.
`default_nettype none

module v3nl_lane (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic               diff_i,
  output logic signed [32:0] v_o,
  output logic        [32:0] m_o,
  output logic        [64:0] sq_o
);

  logic signed [32:0] v_q, v2_q;
  logic        [32:0] m_q, m_d;
  logic        [65:0] prod;
  logic        [64:0] sq_q;

  assign m_d  = v_q[32] ? 33'(-v_q) : 33'(v_q);
  assign prod = 66'(m_d) * 66'(m_d);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q  <= diff_i ? (33'(a_i) - 33'(b_i)) : 33'(a_i);
      v2_q <= v_q;
      m_q  <= m_d;
      sq_q <= prod[64:0];
    end
  end

  assign v_o  = v2_q;
  assign m_o  = m_q;
  assign sq_o = sq_q;

endmodule

`default_nettype wire

// ===== rtl/v3nl_sqrt.sv =====
// Pipelined rounded integer square root, one root bit per stage plus a rounding stage.
// Depends on v3nl_pkg for the stage count and the payload type.
`default_nettype none

module v3nl_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [65:0]         sum_i,
  input  v3nl_pkg::sq_pay_t   pay_i,
  output logic                valid_o,
  output logic [32:0]         len_o,
  output v3nl_pkg::sq_pay_t   pay_o
);
  import v3nl_pkg::*;

  logic [SQRT_STEPS-1:0] vld_q;
  logic [36:0]           rem_q  [SQRT_STEPS];
  logic [33:0]           root_q [SQRT_STEPS];
  logic [67:0]           s_q    [SQRT_STEPS];
  sq_pay_t               pay_q  [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [36:0] rem_in, rem_sh, trial;
    logic [33:0] root_in;
    logic [67:0] s_in;
    sq_pay_t     pay_in;
    logic        vld_in, ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_in    = {2'b00, sum_i};
      assign pay_in  = pay_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign s_in    = s_q[k-1];
      assign pay_in  = pay_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // remainder stays below 2*root, so the top two bits are free to shift out
    assign rem_sh = {rem_in[34:0], s_in[67:66]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[32:0], ge};
        s_q[k]    <= {s_in[65:0], 2'b00};
        pay_q[k]  <= pay_in;
      end
    end
  end

  // round to nearest: bump when S - r^2 > r
  logic        vld_o_q, inc;
  logic [32:0] len_q;
  sq_pay_t     pay_o_q;

  assign inc = (rem_q[SQRT_STEPS-1] > {3'b000, root_q[SQRT_STEPS-1]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o_q <= 1'b0;
    end else if (en_i) begin
      vld_o_q <= vld_q[SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q   <= root_q[SQRT_STEPS-1][32:0] + 33'(inc);
      pay_o_q <= pay_q[SQRT_STEPS-1];
    end
  end

  assign valid_o = vld_o_q;
  assign len_o   = len_q;
  assign pay_o   = pay_o_q;

endmodule

`default_nettype wire

// ===== rtl/v3nl_div.sv =====
// Pipelined restoring divider for one lane: round(m * 2^30 / len), one quotient bit per stage.
// Depends on v3nl_pkg for the stage count.
`default_nettype none

module v3nl_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [32:0] m_i,
  input  logic [32:0] len_i,
  output logic [30:0] q_o
);
  import v3nl_pkg::*;

  logic [62:0] n_q;
  logic [32:0] dlen_q;

  logic [33:0] rem_q [DIV_STEPS];
  logic [30:0] nb_q  [DIV_STEPS];
  logic [32:0] len_q [DIV_STEPS];
  logic [30:0] q_q   [DIV_STEPS];

  // numerator with the half-divisor rounding term
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= {m_i[32:0], 30'd0} + 63'(len_i[32:1]);
      dlen_q <= len_i;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [33:0] rem_in, rem_sh;
    logic [30:0] nb_in, q_in;
    logic [32:0] len_in;
    logic        ge;

    if (k == 0) begin : g_first
      // quotient fits 31 bits, so the top numerator bits are already below len
      assign rem_in = {2'b00, n_q[62:31]};
      assign nb_in  = n_q[30:0];
      assign len_in = dlen_q;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nb_in  = nb_q[k-1];
      assign len_in = len_q[k-1];
      assign q_in   = q_q[k-1];
    end

    assign rem_sh = {rem_in[32:0], nb_in[30]};
    assign ge     = (rem_sh >= {1'b0, len_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? (rem_sh - {1'b0, len_in}) : rem_sh;
        nb_q[k]  <= {nb_in[29:0], 1'b0};
        len_q[k] <= len_in;
        q_q[k]   <= {q_in[29:0], ge};
      end
    end
  end

  assign q_o = q_q[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/vector3_normalize_length.sv =====
// Throughput: one transaction per cycle; the whole pipeline advances together and
// freezes only while a result waits at the output register.
// Stages: 2 lane (difference, square), 1 sum, 35 square root, 32 divide, 1 output.
// Reset: rst_ni clears all valid bits at once; data registers are not reset.
`default_nettype none

module vector3_normalize_length (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] in_x_i,
  input  logic signed [31:0] in_y_i,
  input  logic signed [31:0] in_z_i,
  input  logic signed [31:0] sub_x_i,
  input  logic signed [31:0] sub_y_i,
  input  logic signed [31:0] sub_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic [32:0]        length_o,
  output logic               zero_length_o
);
  import v3nl_pkg::*;

  // Sideband that follows the divider.
  typedef struct packed {
    logic                   byp;   // pass components through unchanged
    logic [LANES-1:0]       neg;
    logic [LANES-1:0][31:0] raw;
    logic [32:0]            len;
  } dl_t;

  // Global advance: the pipeline moves whenever the output register is free.
  logic en;
  logic out_vld_q;
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  op_e  op_in;
  assign op_in = op_e'(operation_i);

  logic signed [31:0] a  [LANES];
  logic signed [31:0] b  [LANES];
  assign a[0] = in_x_i;  assign a[1] = in_y_i;  assign a[2] = in_z_i;
  assign b[0] = sub_x_i; assign b[1] = sub_y_i; assign b[2] = sub_z_i;

  // ---------------- lanes: difference, magnitude, square ----------------
  logic signed [32:0] lv  [LANES];
  logic        [32:0] lm  [LANES];
  logic        [64:0] lsq [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    v3nl_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .a_i    (a[i]),
      .b_i    (b[i]),
      .diff_i (op_in == OP_DIFF),
      .v_o    (lv[i]),
      .m_o    (lm[i]),
      .sq_o   (lsq[i])
    );
  end

  // opcode and valid follow the two lane stages
  logic [1:0] lvld_q;
  op_e        op1_q, op2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvld_q <= '0;
    end else if (en) begin
      lvld_q <= {lvld_q[0], in_valid_i && en};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q <= op_in;
      op2_q <= op1_q;
    end
  end

  // ---------------- merge: sum of squares ----------------
  logic        sum_vld_q;
  logic [65:0] sum_q;
  sq_pay_t     sum_pay_q, sum_pay_d;

  always_comb begin
    sum_pay_d.op = op2_q;
    for (int i = 0; i < LANES; i++) begin
      sum_pay_d.v[i] = lv[i];
      sum_pay_d.m[i] = lm[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
    end else if (en) begin
      sum_vld_q <= lvld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q     <= 66'(lsq[0]) + 66'(lsq[1]) + 66'(lsq[2]);
      sum_pay_q <= sum_pay_d;
    end
  end

  // ---------------- rounded square root ----------------
  logic        sq_vld;
  logic [32:0] sq_len;
  sq_pay_t     sq_pay;

  v3nl_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sum_vld_q),
    .sum_i   (sum_q),
    .pay_i   (sum_pay_q),
    .valid_o (sq_vld),
    .len_o   (sq_len),
    .pay_o   (sq_pay)
  );

  // ---------------- per-lane dividers ----------------
  logic [30:0] quo [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_div
    v3nl_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .m_i   (sq_pay.m[i]),
      .len_i (sq_len),
      .q_o   (quo[i])
    );
  end

  // sideband delay line matched to the divider latency
  dl_t              dl_d;
  dl_t              dl_q   [DIV_LAT];
  logic [DIV_LAT-1:0] dl_vld_q;

  always_comb begin
    dl_d.byp = (sq_pay.op == OP_LEN) || (sq_pay.op == OP_RSVD) || (sq_len == '0);
    dl_d.len = sq_len;
    for (int i = 0; i < LANES; i++) begin
      dl_d.neg[i] = sq_pay.v[i][32];
      dl_d.raw[i] = sq_pay.v[i][31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_vld_q <= '0;
    end else if (en) begin
      dl_vld_q <= {dl_vld_q[DIV_LAT-2:0], sq_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_q[0] <= dl_d;
      for (int k = 1; k < DIV_LAT; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
    end
  end

  // ---------------- output register ----------------
  dl_t         fin;
  logic [31:0] comp_d [LANES];
  logic [31:0] comp_q [LANES];
  logic [32:0] len_q;
  logic        zero_q, byp_q;

  assign fin = dl_q[DIV_LAT-1];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (fin.byp) begin
        comp_d[i] = fin.raw[i];
      end else if (fin.neg[i]) begin
        comp_d[i] = -{1'b0, quo[i]};
      end else begin
        comp_d[i] = {1'b0, quo[i]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dl_vld_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        comp_q[i] <= comp_d[i];
      end
      len_q  <= fin.len;
      zero_q <= (fin.len == '0);
      byp_q  <= fin.byp;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_x_o       = comp_q[0];
  assign out_y_o       = comp_q[1];
  assign out_z_o       = comp_q[2];
  assign length_o      = len_q;
  assign zero_length_o = zero_q;

`ifndef SYNTHESIS
  // normalized components never exceed 1.0 in Q2.30
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !byp_q |->
      ($signed(comp_q[0]) <= 32'sh40000000) && ($signed(comp_q[0]) >= -32'sh40000000) &&
      ($signed(comp_q[1]) <= 32'sh40000000) && ($signed(comp_q[1]) >= -32'sh40000000) &&
      ($signed(comp_q[2]) <= 32'sh40000000) && ($signed(comp_q[2]) >= -32'sh40000000))
    else $error("unit component out of range");

  // a zero length always forces the pass-through path
  a_zero_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && zero_q |-> byp_q)
    else $error("zero length not bypassed");

  // an accepted transaction reaches the lane output valid lvld_q[1] while out_ready_i holds
  a_lane_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && out_ready_i ##1 out_ready_i |=> lvld_q[1])
    else $error("lane valid lost");
`endif

endmodule

`default_nettype wire
